[hdl/ifps_pkg.sv]
// types, codes and constants shared by the isp flash program sequencer
`default_nettype none
package ifps_pkg;

    // words per flash page
    localparam int PAGE_WORDS = 64;
    localparam int PAGE_CNT_W = (PAGE_WORDS > 2) ? $clog2(PAGE_WORDS) : 1;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_REPLY = 2'd1;
    localparam logic [1:0] MODE_IMAGE = 2'd2;
    localparam logic [1:0] MODE_CONT  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_BUSY       = 2'd0;
    localparam logic [1:0] ST_DONE       = 2'd1;
    localparam logic [1:0] ST_SIG_FAIL   = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    // frame lengths
    localparam logic [2:0] FB_NONE  = 3'd0;
    localparam logic [2:0] FB_THREE = 3'd3;
    localparam logic [2:0] FB_FOUR  = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIGNATURE = 1'd1;
    localparam int CFG_DATA_W = 24;
    localparam logic [23:0] SIG_RESET = 24'h1E950F;

    // command opcodes
    localparam logic [7:0] OP_PROG_EN_0  = 8'hAC;
    localparam logic [7:0] OP_PROG_EN_1  = 8'h53;
    localparam logic [7:0] OP_READ_SIG   = 8'h30;
    localparam logic [7:0] OP_ERASE_0    = 8'hAC;
    localparam logic [7:0] OP_ERASE_1    = 8'h80;
    localparam logic [7:0] OP_EEPROM_WR  = 8'hC0;
    localparam logic [7:0] OP_LOAD_LOW   = 8'h40;
    localparam logic [7:0] OP_LOAD_HIGH  = 8'h48;
    localparam logic [7:0] OP_COMMIT     = 8'h4C;
    localparam logic [7:0] PAD_BYTE      = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIG,
        PH_IMAGE,
        PH_PAD,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [31:0] frame;
        logic [2:0]  frame_bytes;
        logic        wants_reply;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // the one or two results that one item causes
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_pair;

    function automatic t_result mk_result(logic [31:0] frame, logic [2:0] nbytes,
                                          logic reply, logic [1:0] status,
                                          logic last);
        t_result r;
        r.frame       = frame;
        r.frame_bytes = nbytes;
        r.wants_reply = reply;
        r.status      = status;
        r.last        = last;
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/isp_flash_program_sequencer.sv]
// top level of the isp flash program sequencer
//
//   channel   dir  handshake                    payload
//   in        in   i_in_valid / o_in_ready      i_in_item  (mode, data)
//   out       out  o_out_valid / i_out_ready    o_out_result (frame .. last)
//   cfg       in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// an accepted item is held in the input register, is turned into its
// one or two results combinationally and, once the queue has room, lands
// in a two-entry result queue; the out port hands out one result per cycle
// while i_out_ready is high; an item with two results needs two transfers;
// the queue lets the next item be taken while earlier results still wait
// reset (synchronous, active low) clears the sequencer to idle, the queue to
// empty and the registers to image length zero and the default signature
// a stalled out port fills the queue and then holds off the in port
`default_nettype none
module isp_flash_program_sequencer (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  ifps_pkg::t_item                        i_in_item,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output ifps_pkg::t_result                      o_out_result,
    input  wire                                    i_cfg_we,
    input  wire  [ifps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [ifps_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import ifps_pkg::*;

    // configuration registers
    logic [15:0] r_image_length;
    logic [23:0] r_expected_signature;

    // input register
    logic  r_in_valid;
    t_item r_in_item;

    logic  q_space;
    logic  move;
    t_pair pair;

    // item leaves the input register when the queue has room
    assign move       = r_in_valid && q_space;
    assign o_in_ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length       <= 16'd0;
            r_expected_signature <= SIG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_LENGTH:       r_image_length <= i_cfg_data[15:0];
                CFG_EXPECTED_SIGNATURE: r_expected_signature <= i_cfg_data[23:0];
                default:                r_image_length <= r_image_length;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    ifps_core u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_fire               (move),
        .i_item               (r_in_item),
        .i_image_length       (r_image_length),
        .i_expected_signature (r_expected_signature),
        .o_pair               (pair)
    );

    ifps_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (move),
        .i_pair   (pair),
        .o_space  (q_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_result)
    );

endmodule
`default_nettype wire

[hdl/ifps_core.sv]
// sequencer state and the per-item result logic
`default_nettype none
module ifps_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  ifps_pkg::t_item        i_item,
    input  wire  [15:0]            i_image_length,
    input  wire  [23:0]            i_expected_signature,
    output ifps_pkg::t_pair        o_pair
);
    import ifps_pkg::*;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_sig_idx, n_sig_idx;
    logic [15:0]           r_word_addr, n_word_addr;
    logic                  r_high_next, n_high_next;
    logic [15:0]           r_bytes_taken, n_bytes_taken;
    logic [PAGE_CNT_W-1:0] r_page_word, n_page_word;

    logic [1:0]  sig_idx;
    logic [7:0]  sig_want;
    logic [15:0] bt_inc;
    logic [15:0] ld_bt;
    logic [7:0]  ld_val;
    logic [15:0] wa_inc;
    logic [15:0] page_start;
    logic        ld_full;
    logic        ld_finished;
    logic [31:0] ld_frame;
    t_result     unexp_res;

    // signature byte to compare
    always_comb begin
        sig_idx = (r_sig_idx > 2'd2) ? 2'd2 : r_sig_idx;
        unique case (sig_idx)
            2'd0:    sig_want = i_expected_signature[23:16];
            2'd1:    sig_want = i_expected_signature[15:8];
            default: sig_want = i_expected_signature[7:0];
        endcase
    end

    // page load shared by image and padding
    always_comb begin
        bt_inc      = r_bytes_taken + 16'd1;
        ld_bt       = (r_phase == PH_IMAGE) ? bt_inc : r_bytes_taken;
        ld_val      = (i_item.mode == MODE_IMAGE) ? i_item.data : PAD_BYTE;
        ld_frame    = {(r_high_next ? OP_LOAD_HIGH : OP_LOAD_LOW),
                       r_word_addr[15:8], r_word_addr[7:0], ld_val};
        wa_inc      = r_word_addr + 16'd1;
        page_start  = wa_inc - 16'(PAGE_WORDS);
        ld_full     = r_high_next && (r_page_word == PAGE_CNT_W'(PAGE_WORDS - 1));
        ld_finished = (r_phase == PH_PAD) || (ld_bt >= i_image_length);
        unexp_res   = mk_result(32'd0, FB_NONE, 1'b0, ST_UNEXPECTED, 1'b1);
    end

    always_comb begin
        n_phase       = r_phase;
        n_sig_idx     = r_sig_idx;
        n_word_addr   = r_word_addr;
        n_high_next   = r_high_next;
        n_bytes_taken = r_bytes_taken;
        n_page_word   = r_page_word;
        o_pair.first  = unexp_res;
        o_pair.second = unexp_res;
        o_pair.two    = 1'b0;

        if (i_item.mode == MODE_START) begin
            n_phase       = PH_SIG;
            n_sig_idx     = 2'd0;
            n_word_addr   = 16'd0;
            n_high_next   = 1'b0;
            n_bytes_taken = 16'd0;
            n_page_word   = '0;
            o_pair.first  = mk_result({OP_PROG_EN_0, OP_PROG_EN_1, 16'd0},
                                      FB_FOUR, 1'b0, ST_BUSY, 1'b0);
            o_pair.second = mk_result({OP_READ_SIG, 24'd0}, FB_THREE, 1'b1,
                                      ST_BUSY, 1'b1);
            o_pair.two    = 1'b1;
        end else if (i_item.mode == MODE_REPLY && r_phase == PH_SIG) begin
            if (i_item.data != sig_want) begin
                n_phase      = PH_FAIL;
                o_pair.first = mk_result(32'd0, FB_NONE, 1'b0, ST_SIG_FAIL, 1'b1);
            end else if (sig_idx < 2'd2) begin
                n_sig_idx    = sig_idx + 2'd1;
                o_pair.first = mk_result({OP_READ_SIG, 8'd0, 6'd0, sig_idx + 2'd1, 8'd0},
                                         FB_THREE, 1'b1, ST_BUSY, 1'b1);
            end else begin
                n_phase       = (i_image_length == 16'd0) ? PH_DONE : PH_IMAGE;
                o_pair.first  = mk_result({OP_ERASE_0, OP_ERASE_1, 16'd0},
                                          FB_FOUR, 1'b0, ST_BUSY, 1'b0);
                o_pair.second = mk_result({OP_EEPROM_WR, 24'd0}, FB_FOUR, 1'b0,
                                          (i_image_length == 16'd0) ? ST_DONE : ST_BUSY,
                                          1'b1);
                o_pair.two    = 1'b1;
            end
        end else if ((i_item.mode == MODE_IMAGE && r_phase == PH_IMAGE) ||
                     (i_item.mode == MODE_CONT && r_phase == PH_PAD)) begin
            n_bytes_taken = ld_bt;
            n_high_next   = !r_high_next;
            if (r_high_next) begin
                n_word_addr = wa_inc;
                n_page_word = ld_full ? '0 : r_page_word + PAGE_CNT_W'(1);
            end
            if (!ld_full) begin
                o_pair.first = mk_result(ld_frame, FB_FOUR, 1'b0, ST_BUSY, 1'b1);
                if (r_phase == PH_IMAGE && ld_bt >= i_image_length) begin
                    n_phase = PH_PAD;
                end
            end else begin
                o_pair.first  = mk_result(ld_frame, FB_FOUR, 1'b0, ST_BUSY, 1'b0);
                o_pair.second = mk_result({OP_COMMIT, page_start[15:8],
                                           page_start[7:0], 8'd0},
                                          FB_FOUR, 1'b0,
                                          ld_finished ? ST_DONE : ST_BUSY, 1'b1);
                o_pair.two    = 1'b1;
                if (ld_finished) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_sig_idx     <= 2'd0;
            r_word_addr   <= 16'd0;
            r_high_next   <= 1'b0;
            r_bytes_taken <= 16'd0;
            r_page_word   <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_sig_idx     <= n_sig_idx;
            r_word_addr   <= n_word_addr;
            r_high_next   <= n_high_next;
            r_bytes_taken <= n_bytes_taken;
            r_page_word   <= n_page_word;
        end
    end

`ifndef NO_ASSERTIONS
    // signature index never runs past the third byte
    a_sig_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sig_idx != 2'd3)
        else $error("signature index out of range");

    // start clears the load position
    a_high_clear_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == MODE_START) |=>
            (r_high_next == 1'b0 && r_page_word == '0 && r_word_addr == 16'd0))
        else $error("start did not clear load position");

    // entering the pad phase from the image phase only happens once the image is consumed
    a_pad_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_IMAGE && n_phase == PH_PAD) |->
            (ld_bt >= i_image_length))
        else $error("pad phase entered early");
`endif

endmodule
`default_nettype wire

[hdl/ifps_out_queue.sv]
// two-entry result queue that hands out one result per transfer
`default_nettype none
module ifps_out_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ifps_pkg::t_pair     i_pair,
    output logic                o_space,
    output logic                o_valid,
    input  wire                 i_ready,
    output ifps_pkg::t_result   o_result
);
    import ifps_pkg::*;

    t_pair      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;
    logic       pop;
    logic       take;

    assign o_space  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_sub ? r_mem[r_rd_ptr].second : r_mem[r_rd_ptr].first;
    assign take     = o_valid && i_ready;
    assign pop      = take && (r_sub || !r_mem[r_rd_ptr].two);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (take) begin
                r_sub <= 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // never more than two pending pairs
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue overflow");

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push while full");

    // after a non-final result is taken its partner follows
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_result.last) |=> (o_valid && r_sub))
        else $error("second result missing");
`endif

endmodule
`default_nettype wire
